[design/bfd_pkg.sv]
// Package for the box filter downscaler: sizes, derived widths, lane control
// and result pixel types. No dependencies.
package bfd_pkg;

  localparam int OUT_SIZE = 128;
  localparam int FACTOR   = 2;
  localparam int CHANNELS = 4;

  localparam int SUB_W = (FACTOR > 1) ? $clog2(FACTOR) : 1;
  localparam int OC_W  = (OUT_SIZE > 1) ? $clog2(OUT_SIZE) : 1;

  localparam int DIV      = FACTOR * FACTOR;
  localparam int SUM_W    = $clog2(DIV * 255 + 1);
  localparam int RECIP_SH = 24;
  localparam int RECIP_W  = RECIP_SH + 1;
  localparam int RECIP    = ((1 << RECIP_SH) + DIV - 1) / DIV;
  localparam int PROD_W   = SUM_W + RECIP_W;

  localparam int FIFO_DEPTH = 4;
  localparam int FPTR_W     = 2;
  localparam int FCNT_W     = 3;

  typedef struct packed {
    logic            accept;
    logic            first_col;
    logic            last_col;
    logic            first_row;
    logic [OC_W-1:0] addr;
  } lane_ctl_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;
    logic       frame_end;
  } pix_t;

endpackage

[design/bfd_if.sv]
// Valid/ready channel interfaces for the source pixel and result pixel streams.
// No dependencies.
interface bfd_in_if;
  logic       valid;
  logic       ready;
  logic       frame_start;
  logic [7:0] red_in;
  logic [7:0] green_in;
  logic [7:0] blue_in;
  logic [7:0] alpha_in;

  modport source (output valid, frame_start, red_in, green_in, blue_in, alpha_in,
                  input ready);
  modport sink   (input valid, frame_start, red_in, green_in, blue_in, alpha_in,
                  output ready);
endinterface

interface bfd_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] red_out;
  logic [7:0] green_out;
  logic [7:0] blue_out;
  logic [7:0] alpha_out;
  logic       frame_end;

  modport source (output valid, red_out, green_out, blue_out, alpha_out, frame_end,
                  input ready);
  modport sink   (input valid, red_out, green_out, blue_out, alpha_out, frame_end,
                  output ready);
endinterface

[design/bfd_lane.sv]
// One channel lane: horizontal run sum, per-column line store with
// read-add-write and bypass, and divide by FACTOR squared. Uses bfd_pkg.
module bfd_lane (
  input  logic              clk,
  input  logic              rst_n,
  input  bfd_pkg::lane_ctl_t ctl,
  input  logic [7:0]        pix,
  output logic [7:0]        avg
);
  import bfd_pkg::*;

  localparam logic [RECIP_W-1:0] RECIP_V = RECIP_W'(RECIP);

  logic [SUM_W-1:0]  mem [OUT_SIZE];
  logic [SUM_W-1:0]  part_r, part_nxt;
  logic              s1_v_r;
  logic              s1_first_r;
  logic [OC_W-1:0]   s1_addr_r;
  logic [SUM_W-1:0]  s1_part_r;
  logic [SUM_W-1:0]  rd_data_r;
  logic              byp_r;
  logic [SUM_W-1:0]  byp_data_r;
  logic [SUM_W-1:0]  sum;
  logic [SUM_W-1:0]  s2_sum_r;
  logic [PROD_W-1:0] prod;
  logic              store;

  assign store    = ctl.accept && ctl.last_col;
  assign part_nxt = ctl.first_col ? SUM_W'(pix) : part_r + SUM_W'(pix);
  assign sum      = s1_part_r + (s1_first_r ? '0 : (byp_r ? byp_data_r : rd_data_r));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else begin
      s1_v_r <= store;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.accept) begin
      part_r <= part_nxt;
    end
    if (store) begin
      rd_data_r  <= mem[ctl.addr];
      byp_r      <= s1_v_r && (s1_addr_r == ctl.addr);
      byp_data_r <= sum;
      s1_first_r <= ctl.first_row;
      s1_addr_r  <= ctl.addr;
      s1_part_r  <= part_nxt;
    end
    if (s1_v_r) begin
      mem[s1_addr_r] <= sum;
      s2_sum_r       <= sum;
    end
  end

  // reciprocal multiply, exact for sums below 2^SUM_W
  assign prod = PROD_W'(s2_sum_r) * PROD_W'(RECIP_V);
  assign avg  = prod[RECIP_SH+7 -: 8];

endmodule

[design/bfd_out_fifo.sv]
// Merge stage: joins the lane averages and frame_end into one result pixel
// and queues it in a small FIFO toward the output channel. Uses bfd_pkg.
module bfd_out_fifo (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       push,
  input  logic [7:0]                 avg [bfd_pkg::CHANNELS],
  input  logic                       frame_end,
  output logic [bfd_pkg::FCNT_W-1:0] count,
  output bfd_pkg::pix_t              head,
  output logic                       head_valid,
  input  logic                       pop
);
  import bfd_pkg::*;

  pix_t              buf_r [FIFO_DEPTH];
  logic [FPTR_W-1:0] wptr_r, rptr_r;
  logic [FCNT_W-1:0] cnt_r;
  pix_t              wdata;
  logic              do_pop;

  assign wdata      = '{red: avg[0], green: avg[1], blue: avg[2], alpha: avg[3],
                        frame_end: frame_end};
  assign head_valid = (cnt_r != '0);
  assign do_pop     = pop && head_valid;
  assign head       = buf_r[rptr_r];
  assign count      = cnt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      if (push) wptr_r <= wptr_r + 1'b1;
      if (do_pop) rptr_r <= rptr_r + 1'b1;
      cnt_r <= cnt_r + FCNT_W'(push) - FCNT_W'(do_pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      buf_r[wptr_r] <= wdata;
    end
  end

endmodule

[design/box_filter_downscale.sv]
// Top level of the box filter downscaler: position counters, four channel
// lanes and the result merge FIFO. Uses bfd_pkg, bfd_if, bfd_lane, bfd_out_fifo.
//
//   channel  port   direction  moves per transfer
//   input    in_s   sink       frame_start, red/green/blue/alpha_in
//   output   out_m  source     red/green/blue/alpha_out, frame_end
//
// One source pixel per clock while in_s.ready is high. A block's result passes
// the lane stage-one and sum registers, in step with e1_r and e2_r, then enters
// the output FIFO that feeds out_m; the read-add-write loop has a one-entry bypass.
// Reset clears the counters and the pipeline; the line store is not cleared, since
// each entry is written on the first row of a block before it is read. in_s.ready
// drops while queued plus in-flight results fill the four-entry output FIFO.
module box_filter_downscale (
  input  logic      clk,
  input  logic      rst_n,
  bfd_in_if.sink    in_s,
  bfd_out_if.source out_m
);
  import bfd_pkg::*;

  localparam logic [SUB_W-1:0] SUB_LAST = SUB_W'(FACTOR - 1);
  localparam logic [OC_W-1:0]  OC_LAST  = OC_W'(OUT_SIZE - 1);

  logic [SUB_W-1:0]  sc_r, sr_r, sc_nxt, sr_nxt, sc, sr;
  logic [OC_W-1:0]   oc_r, or_r, oc_nxt, or_nxt, oc, orw;
  logic              accept;
  logic              emit;
  logic              e1_r, e2_r, fe1_r, fe2_r;
  lane_ctl_t         ctl;
  logic [7:0]        pix [CHANNELS];
  logic [7:0]        avg [CHANNELS];
  logic [FCNT_W-1:0] fcount;
  pix_t              head;
  logic              head_valid;

  assign accept = in_s.valid && in_s.ready;
  assign in_s.ready = (fcount + FCNT_W'(e1_r) + FCNT_W'(e2_r)) <= FCNT_W'(FIFO_DEPTH - 1);

  assign sc  = in_s.frame_start ? '0 : sc_r;
  assign sr  = in_s.frame_start ? '0 : sr_r;
  assign oc  = in_s.frame_start ? '0 : oc_r;
  assign orw = in_s.frame_start ? '0 : or_r;

  always_comb begin
    sc_nxt = sc;
    sr_nxt = sr;
    oc_nxt = oc;
    or_nxt = orw;
    if (sc == SUB_LAST) begin
      sc_nxt = '0;
      if (oc == OC_LAST) begin
        oc_nxt = '0;
        if (sr == SUB_LAST) begin
          sr_nxt = '0;
          or_nxt = (orw == OC_LAST) ? '0 : orw + 1'b1;
        end else begin
          sr_nxt = sr + 1'b1;
        end
      end else begin
        oc_nxt = oc + 1'b1;
      end
    end else begin
      sc_nxt = sc + 1'b1;
    end
  end

  assign emit = (sc == SUB_LAST) && (sr == SUB_LAST);

  assign ctl = '{accept: accept, first_col: (sc == '0), last_col: (sc == SUB_LAST),
                 first_row: (sr == '0), addr: oc};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sc_r  <= '0;
      sr_r  <= '0;
      oc_r  <= '0;
      or_r  <= '0;
      e1_r  <= 1'b0;
      e2_r  <= 1'b0;
      fe1_r <= 1'b0;
      fe2_r <= 1'b0;
    end else begin
      if (accept) begin
        sc_r <= sc_nxt;
        sr_r <= sr_nxt;
        oc_r <= oc_nxt;
        or_r <= or_nxt;
      end
      e1_r  <= accept && emit;
      fe1_r <= (oc == OC_LAST) && (orw == OC_LAST);
      e2_r  <= e1_r;
      fe2_r <= fe1_r;
    end
  end

  assign pix[0] = in_s.red_in;
  assign pix[1] = in_s.green_in;
  assign pix[2] = in_s.blue_in;
  assign pix[3] = in_s.alpha_in;

  for (genvar g = 0; g < CHANNELS; g++) begin : g_lane
    bfd_lane u_lane (
      .clk   (clk),
      .rst_n (rst_n),
      .ctl   (ctl),
      .pix   (pix[g]),
      .avg   (avg[g])
    );
  end

  bfd_out_fifo u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (e2_r),
    .avg        (avg),
    .frame_end  (fe2_r),
    .count      (fcount),
    .head       (head),
    .head_valid (head_valid),
    .pop        (out_m.ready)
  );

  assign out_m.valid     = head_valid;
  assign out_m.red_out   = head.red;
  assign out_m.green_out = head.green;
  assign out_m.blue_out  = head.blue;
  assign out_m.alpha_out = head.alpha;
  assign out_m.frame_end = head.frame_end;

endmodule
